// ===== rtl/tetc_pkg.sv =====
`default_nettype none
package tetc_pkg;

  // Number of pipeline stages (input, difference, product, compare, output)
  localparam int unsigned NUM_STAGES = 5;

  // Vertex pairs that form the edges of the first triangle (AB, AC, BC)
  localparam int unsigned EA [3] = '{0, 0, 1};
  localparam int unsigned EB [3] = '{1, 2, 2};
  // Vertex pairs that form the edges of the second triangle (AB, AC, CB)
  localparam int unsigned FA [3] = '{0, 0, 2};
  localparam int unsigned FB [3] = '{1, 2, 1};

  // Per-stage load enables handed from the pipeline control to the datapath
  typedef struct packed {
    logic a;
    logic b;
    logic c;
    logic d;
    logic e;
  } stage_en_t;

  // Outcome of one orientation test plus its on-segment check
  typedef struct packed {
    logic neg;
    logic zero;
    logic onseg;
  } orient_t;

endpackage
`default_nettype wire

// ===== rtl/triangle_edge_crossing_test_top.sv =====
// Channel   Ports                                   Direction  Transfer
// input     in_valid, in_ready, in_tri{0,1}_*       in         one triangle pair
// result    out_valid, out_ready, out_crossed       out        one crossing flag
//
// Five register stages: input, differences, products, sign compare, output.
// out_valid is the valid bit of the output stage; one pair per cycle while out_ready is high.
// The 17x17 (at default width) products in the product stage set the cycle time.
// Reset (rst_n low, synchronous) clears only the stage valid bits.
// Stalls back up stage by stage; an empty stage still takes a new item.
`default_nettype none
module triangle_edge_crossing_test_top
  import tetc_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic signed [COORD_WIDTH-1:0] in_tri0_ax,
  input  wire logic signed [COORD_WIDTH-1:0] in_tri0_ay,
  input  wire logic signed [COORD_WIDTH-1:0] in_tri0_bx,
  input  wire logic signed [COORD_WIDTH-1:0] in_tri0_by,
  input  wire logic signed [COORD_WIDTH-1:0] in_tri0_cx,
  input  wire logic signed [COORD_WIDTH-1:0] in_tri0_cy,
  input  wire logic signed [COORD_WIDTH-1:0] in_tri1_ax,
  input  wire logic signed [COORD_WIDTH-1:0] in_tri1_ay,
  input  wire logic signed [COORD_WIDTH-1:0] in_tri1_bx,
  input  wire logic signed [COORD_WIDTH-1:0] in_tri1_by,
  input  wire logic signed [COORD_WIDTH-1:0] in_tri1_cx,
  input  wire logic signed [COORD_WIDTH-1:0] in_tri1_cy,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               out_crossed
);

  stage_en_t en;

  logic signed [COORD_WIDTH-1:0] t0x_r [3];
  logic signed [COORD_WIDTH-1:0] t0y_r [3];
  logic signed [COORD_WIDTH-1:0] t1x_r [3];
  logic signed [COORD_WIDTH-1:0] t1y_r [3];

  orient_t o1 [3][3];
  orient_t o0 [3][3];

  // Valid/ready chain for all stages
  tetc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .en        (en)
  );

  // Stage A: capture the vertices
  always_ff @(posedge clk) begin
    if (en.a) begin
      t0x_r[0] <= in_tri0_ax;
      t0y_r[0] <= in_tri0_ay;
      t0x_r[1] <= in_tri0_bx;
      t0y_r[1] <= in_tri0_by;
      t0x_r[2] <= in_tri0_cx;
      t0y_r[2] <= in_tri0_cy;
      t1x_r[0] <= in_tri1_ax;
      t1y_r[0] <= in_tri1_ay;
      t1x_r[1] <= in_tri1_bx;
      t1y_r[1] <= in_tri1_by;
      t1x_r[2] <= in_tri1_cx;
      t1y_r[2] <= in_tri1_cy;
    end
  end

  // Eighteen orientation units: each edge against each vertex of the other triangle
  for (genvar e = 0; e < 3; e++) begin : g_edge
    for (genvar k = 0; k < 3; k++) begin : g_vtx
      tetc_orient #(.COORD_WIDTH(COORD_WIDTH)) u_o1 (
        .clk (clk),
        .en  (en),
        .p_x (t1x_r[FA[e]]),
        .p_y (t1y_r[FA[e]]),
        .q_x (t1x_r[FB[e]]),
        .q_y (t1y_r[FB[e]]),
        .r_x (t0x_r[k]),
        .r_y (t0y_r[k]),
        .res (o1[e][k])
      );

      tetc_orient #(.COORD_WIDTH(COORD_WIDTH)) u_o0 (
        .clk (clk),
        .en  (en),
        .p_x (t0x_r[EA[e]]),
        .p_y (t0y_r[EA[e]]),
        .q_x (t0x_r[EB[e]]),
        .q_y (t0y_r[EB[e]]),
        .r_x (t1x_r[k]),
        .r_y (t1y_r[k]),
        .res (o0[e][k])
      );
    end
  end

  // Stage E: merge the nine segment pair tests
  tetc_combine u_combine (
    .clk     (clk),
    .en      (en),
    .o1      (o1),
    .o0      (o0),
    .crossed (out_crossed)
  );

endmodule
`default_nettype wire

// ===== rtl/tetc_ctrl.sv =====
`default_nettype none
module tetc_ctrl
  import tetc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  wire logic      out_ready,
  output stage_en_t      en
);

  logic [NUM_STAGES-1:0] vld_r;
  logic [NUM_STAGES-1:0] vld_nxt;
  logic [NUM_STAGES-1:0] rdy;

  // A stage can load when it is empty or its content moves on
  always_comb begin
    rdy[NUM_STAGES-1] = !vld_r[NUM_STAGES-1] || out_ready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  // Valid bits follow the data
  always_comb begin
    vld_nxt = vld_r;
    if (rdy[0]) begin
      vld_nxt[0] = in_valid;
    end
    for (int k = 1; k < NUM_STAGES; k++) begin
      if (rdy[k]) begin
        vld_nxt[k] = vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = vld_r[NUM_STAGES-1];
  assign en.a      = rdy[0];
  assign en.b      = rdy[1];
  assign en.c      = rdy[2];
  assign en.d      = rdy[3];
  assign en.e      = rdy[4];

  // Accepted transaction lands in the input stage
  a_in_load: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> vld_r[0])
    else $error("accepted transaction not captured");

  // A blocked product stage keeps its item
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[2] && !rdy[3]) |=> vld_r[2])
    else $error("blocked stage dropped its item");

  // An item moving forward from the compare stage arrives in the output stage
  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[3] && rdy[4]) |=> vld_r[4])
    else $error("item lost between compare and output stage");

  // Empty output stage never blocks the input
  a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (!vld_r[4] && !vld_r[0]) |-> in_ready)
    else $error("input stalled with room in the pipeline");

endmodule
`default_nettype wire

// ===== rtl/tetc_orient.sv =====
`default_nettype none
module tetc_orient
  import tetc_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = 16
) (
  input  wire logic                          clk,
  input  wire stage_en_t                     en,
  input  wire logic signed [COORD_WIDTH-1:0] p_x,
  input  wire logic signed [COORD_WIDTH-1:0] p_y,
  input  wire logic signed [COORD_WIDTH-1:0] q_x,
  input  wire logic signed [COORD_WIDTH-1:0] q_y,
  input  wire logic signed [COORD_WIDTH-1:0] r_x,
  input  wire logic signed [COORD_WIDTH-1:0] r_y,
  output orient_t                            res
);

  localparam int unsigned DW = COORD_WIDTH + 1;
  localparam int unsigned PW = 2 * COORD_WIDTH + 2;

  logic signed [DW-1:0] qx_nxt, qy_nxt, rx_nxt, ry_nxt;
  logic signed [DW-1:0] qx_r, qy_r, rx_r, ry_r;
  logic                 box_nxt;
  logic                 box_b_r, box_c_r;
  logic signed [PW-1:0] m1_r, m2_r;
  orient_t              res_r;

  // Stage B: edge and point differences, bounding box check
  assign qx_nxt = {q_x[COORD_WIDTH-1], q_x} - {p_x[COORD_WIDTH-1], p_x};
  assign qy_nxt = {q_y[COORD_WIDTH-1], q_y} - {p_y[COORD_WIDTH-1], p_y};
  assign rx_nxt = {r_x[COORD_WIDTH-1], r_x} - {p_x[COORD_WIDTH-1], p_x};
  assign ry_nxt = {r_y[COORD_WIDTH-1], r_y} - {p_y[COORD_WIDTH-1], p_y};
  assign box_nxt = (r_x >= p_x || r_x >= q_x) && (r_x <= p_x || r_x <= q_x) &&
                   (r_y >= p_y || r_y >= q_y) && (r_y <= p_y || r_y <= q_y);

  always_ff @(posedge clk) begin
    if (en.b) begin
      qx_r    <= qx_nxt;
      qy_r    <= qy_nxt;
      rx_r    <= rx_nxt;
      ry_r    <= ry_nxt;
      box_b_r <= box_nxt;
    end
  end

  // Stage C: the two cross product terms
  always_ff @(posedge clk) begin
    if (en.c) begin
      m1_r    <= qx_r * ry_r;
      m2_r    <= qy_r * rx_r;
      box_c_r <= box_b_r;
    end
  end

  // Stage D: sign of the cross product and the on-segment flag
  always_ff @(posedge clk) begin
    if (en.d) begin
      res_r.neg   <= m1_r < m2_r;
      res_r.zero  <= m1_r == m2_r;
      res_r.onseg <= (m1_r == m2_r) && box_c_r;
    end
  end

  assign res = res_r;

endmodule
`default_nettype wire

// ===== rtl/tetc_combine.sv =====
`default_nettype none
module tetc_combine
  import tetc_pkg::*;
(
  input  wire logic      clk,
  input  wire stage_en_t en,
  input  wire orient_t   o1 [3][3],
  input  wire orient_t   o0 [3][3],
  output logic           crossed
);

  logic hit_nxt;
  logic crossed_r;

  // o1[j][k]: edge j of the second triangle against vertex k of the first
  // o0[i][k]: edge i of the first triangle against vertex k of the second
  always_comb begin
    orient_t d1, d2, d3, d4;
    logic    prop, touch;
    hit_nxt = 1'b0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        d1 = o1[j][EA[i]];
        d2 = o1[j][EB[i]];
        d3 = o0[i][FA[j]];
        d4 = o0[i][FB[j]];
        // proper crossing: endpoints strictly on opposite sides both ways
        prop = ((d1.neg && !d2.neg && !d2.zero) || (d2.neg && !d1.neg && !d1.zero)) &&
               ((d3.neg && !d4.neg && !d4.zero) || (d4.neg && !d3.neg && !d3.zero));
        touch = d1.onseg || d2.onseg || d3.onseg || d4.onseg;
        hit_nxt = hit_nxt || prop || touch;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en.e) begin
      crossed_r <= hit_nxt;
    end
  end

  assign crossed = crossed_r;

endmodule
`default_nettype wire
